// ===== rtl/dft_pkg.sv =====
// ----------------------------------------------------------------------------
// dft_pkg
// shared types and constants for the dual fan temperature curve block
// ----------------------------------------------------------------------------
package dft_pkg;

  localparam int TEMP_W  = 12;
  localparam int PCT_W   = 7;
  localparam int CFG_AW  = 5;
  localparam int CFG_DW  = 32;
  localparam int DIVN_W  = 20;   // 2*num + d, num up to 4095*100
  localparam int DIVD_W  = 13;   // 2*d
  localparam int QUO_W   = 7;    // quotient never above 100
  localparam int PROD_W  = 19;

  localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;

  // register map, index = paddr[4:2]
  typedef enum logic [2:0] {
    REG_CAP_ON    = 3'd0,
    REG_CAP_FULL  = 3'd1,
    REG_CAP_OFF   = 3'd2,
    REG_SINK_ON   = 3'd3,
    REG_SINK_FULL = 3'd4,
    REG_SINK_OFF  = 3'd5,
    REG_MIN_RUN   = 3'd6,
    REG_DEADBAND  = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic signed [TEMP_W-1:0] cap_on;
    logic signed [TEMP_W-1:0] cap_full;
    logic signed [TEMP_W-1:0] cap_off;
    logic signed [TEMP_W-1:0] sink_on;
    logic signed [TEMP_W-1:0] sink_full;
    logic signed [TEMP_W-1:0] sink_off;
    logic [PCT_W-1:0]         min_run;
    logic [PCT_W-1:0]         deadband;
  } cfg_regs_t;

  typedef struct packed {
    logic              start;
    logic [DIVN_W-1:0] dividend;
    logic [DIVD_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [QUO_W-1:0] quotient;
  } div_rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_MUL,
    ST_CHK,
    ST_DIV,
    ST_APPLY,
    ST_OUT
  } state_t;

endpackage

// ===== rtl/dft_cfg.sv =====
// ----------------------------------------------------------------------------
// dft_cfg
// apb register file holding fan thresholds, min run and deadband
// ----------------------------------------------------------------------------
module dft_cfg import dft_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready,
  output cfg_regs_t         cfg
);

  cfg_regs_t cfg_r;
  reg_idx_t  idx;
  logic      wr_en;

  assign idx    = reg_idx_t'(paddr[CFG_AW-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.cap_on    <= 12'sd640;
      cfg_r.cap_full  <= 12'sd960;
      cfg_r.cap_off   <= 12'sd560;
      cfg_r.sink_on   <= 12'sd720;
      cfg_r.sink_full <= 12'sd1120;
      cfg_r.sink_off  <= 12'sd640;
      cfg_r.min_run   <= 7'd20;
      cfg_r.deadband  <= 7'd3;
    end else if (wr_en) begin
      unique case (idx)
        REG_CAP_ON:    cfg_r.cap_on    <= pwdata[TEMP_W-1:0];
        REG_CAP_FULL:  cfg_r.cap_full  <= pwdata[TEMP_W-1:0];
        REG_CAP_OFF:   cfg_r.cap_off   <= pwdata[TEMP_W-1:0];
        REG_SINK_ON:   cfg_r.sink_on   <= pwdata[TEMP_W-1:0];
        REG_SINK_FULL: cfg_r.sink_full <= pwdata[TEMP_W-1:0];
        REG_SINK_OFF:  cfg_r.sink_off  <= pwdata[TEMP_W-1:0];
        REG_MIN_RUN:   cfg_r.min_run   <= pwdata[PCT_W-1:0];
        REG_DEADBAND:  cfg_r.deadband  <= pwdata[PCT_W-1:0];
        default:       ;
      endcase
    end
  end

  // temperatures read back sign extended
  always_comb begin
    unique case (idx)
      REG_CAP_ON:    prdata = {{(CFG_DW-TEMP_W){cfg_r.cap_on[TEMP_W-1]}}, cfg_r.cap_on};
      REG_CAP_FULL:  prdata = {{(CFG_DW-TEMP_W){cfg_r.cap_full[TEMP_W-1]}}, cfg_r.cap_full};
      REG_CAP_OFF:   prdata = {{(CFG_DW-TEMP_W){cfg_r.cap_off[TEMP_W-1]}}, cfg_r.cap_off};
      REG_SINK_ON:   prdata = {{(CFG_DW-TEMP_W){cfg_r.sink_on[TEMP_W-1]}}, cfg_r.sink_on};
      REG_SINK_FULL: prdata = {{(CFG_DW-TEMP_W){cfg_r.sink_full[TEMP_W-1]}}, cfg_r.sink_full};
      REG_SINK_OFF:  prdata = {{(CFG_DW-TEMP_W){cfg_r.sink_off[TEMP_W-1]}}, cfg_r.sink_off};
      REG_MIN_RUN:   prdata = {{(CFG_DW-PCT_W){1'b0}}, cfg_r.min_run};
      REG_DEADBAND:  prdata = {{(CFG_DW-PCT_W){1'b0}}, cfg_r.deadband};
      default:       prdata = '0;
    endcase
  end

endmodule

// ===== rtl/dft_div.sv =====
// ----------------------------------------------------------------------------
// dft_div
// restoring divider, one quotient bit per cycle, shared by both fans
// ----------------------------------------------------------------------------
module dft_div import dft_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int SH_W  = DIVD_W + QUO_W - 1;
  localparam int CNT_W = $clog2(QUO_W);

  logic [DIVN_W-1:0] rem_r,  rem_nxt;
  logic [SH_W-1:0]   dsh_r;
  logic [QUO_W-1:0]  quo_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              busy_r;
  logic              done_r;
  logic              ge;

  // trial subtract of the aligned divisor
  assign ge      = rem_r >= {{(DIVN_W-SH_W){1'b0}}, dsh_r};
  assign rem_nxt = ge ? rem_r - {{(DIVN_W-SH_W){1'b0}}, dsh_r} : rem_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == '0);
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(QUO_W - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= req.dividend;
      dsh_r <= {req.divisor, {(QUO_W-1){1'b0}}};
      quo_r <= '0;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      dsh_r <= dsh_r >> 1;
      quo_r <= {quo_r[QUO_W-2:0], ge};
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

// ===== rtl/dual_fan_temp_curve_hysteresis.sv =====
// ----------------------------------------------------------------------------
// dual_fan_temp_curve_hysteresis
// two fan curves with hysteresis, min run level and command deadband
// ----------------------------------------------------------------------------
// sequence: each fan passes PREP and APPLY; a ramp adds MUL and CHK and
//   then a clip to min run or a rounded divide in DIV
// input: a new beat is taken only in IDLE; the fans use the shared 7-step
//   divider in turn (capacitor fan first, then heatsink fan)
// reset: synchronous active-low; config back to defaults, commands to 0
// ----------------------------------------------------------------------------
module dual_fan_temp_curve_hysteresis import dft_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  // input channel
  input  logic              in_tvalid,
  output logic              in_tready,
  // supply_ok, sink_temp, sink_valid, board0_temp, board0_valid,
  // board1_temp, board1_valid
  input  logic [39:0]       in_tdata,
  // result channel
  output logic              out_tvalid,
  input  logic              out_tready,
  // cap_cmd_pct, cap_cmd_new, sink_cmd_pct, sink_cmd_new
  output logic [15:0]       out_tdata,
  // configuration port
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready
);

  cfg_regs_t cfg;
  div_req_t  div_req;
  div_rsp_t  div_rsp;

  dft_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  dft_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // input beat fields
  logic                     in_supply;
  logic signed [TEMP_W-1:0] in_sink_t, in_b0_t, in_b1_t;
  logic                     in_sink_v, in_b0_v, in_b1_v;

  assign in_supply = in_tdata[0];
  assign in_sink_t = in_tdata[12:1];
  assign in_sink_v = in_tdata[13];
  assign in_b0_t   = in_tdata[25:14];
  assign in_b0_v   = in_tdata[26];
  assign in_b1_t   = in_tdata[38:27];
  assign in_b1_v   = in_tdata[39];

  state_t state_r, state_nxt;

  // latched tick
  logic                     supply_r;
  logic signed [TEMP_W-1:0] tc_r, ts_r;
  logic                     vc_r, vs_r;
  logic signed [TEMP_W-1:0] tc_sel;

  // per-fan working registers
  logic                     fan_r;     // 0 capacitor fan, 1 heatsink fan
  logic [TEMP_W-1:0]        diff_r;    // t - on
  logic [TEMP_W-1:0]        d_r;       // full - on
  logic [PROD_W-1:0]        num_r;     // (t - on) * 100
  logic [PROD_W-1:0]        mrd_r;     // min(min_run, 100) * (full - on)
  logic [PCT_W-1:0]         dem_r;     // demand of the current fan

  logic [PCT_W-1:0]         cap_last_r, sink_last_r;
  logic                     cap_new_r, sink_new_r;

  logic                     out_tvalid_r;
  logic [15:0]              out_tdata_r;

  // control from the sequencer
  logic                     accept;
  logic                     load_out;
  logic                     out_free;

  // hotter valid board sensor drives the capacitor fan
  always_comb begin
    if (in_b0_v && in_b1_v) begin
      tc_sel = (in_b0_t > in_b1_t) ? in_b0_t : in_b1_t;
    end else if (in_b0_v) begin
      tc_sel = in_b0_t;
    end else begin
      tc_sel = in_b1_t;
    end
  end

  // current fan operand selection
  logic signed [TEMP_W-1:0] t_cur, on_cur, full_cur, off_cur;
  logic                     v_cur;
  logic [PCT_W-1:0]         last_cur;
  logic [PCT_W-1:0]         mr_sat;
  logic                     ramp;
  logic [PCT_W-1:0]         dem_direct;
  logic [TEMP_W:0]          diff_w, d_w;

  assign t_cur    = fan_r ? ts_r           : tc_r;
  assign v_cur    = fan_r ? vs_r           : vc_r;
  assign on_cur   = fan_r ? cfg.sink_on    : cfg.cap_on;
  assign full_cur = fan_r ? cfg.sink_full  : cfg.cap_full;
  assign off_cur  = fan_r ? cfg.sink_off   : cfg.cap_off;
  assign last_cur = fan_r ? sink_last_r    : cap_last_r;
  assign mr_sat   = (cfg.min_run > PCT_FULL) ? PCT_FULL : cfg.min_run;

  // only the ramp case uses these, where both are in 0..4095
  assign diff_w = {t_cur[TEMP_W-1], t_cur} - {on_cur[TEMP_W-1], on_cur};
  assign d_w    = {full_cur[TEMP_W-1], full_cur} - {on_cur[TEMP_W-1], on_cur};

  // curve checks in priority order; supply loss forces zero
  always_comb begin
    ramp       = 1'b0;
    dem_direct = last_cur;
    priority if (!supply_r) begin
      dem_direct = '0;
    end else if (!v_cur) begin
      dem_direct = last_cur;
    end else if (t_cur <= off_cur) begin
      dem_direct = '0;
    end else if (t_cur < on_cur) begin
      dem_direct = last_cur;
    end else if (t_cur >= full_cur) begin
      dem_direct = PCT_FULL;
    end else begin
      ramp = 1'b1;
    end
  end

  // below min run level, or start rounded division
  logic below_mr;
  assign below_mr = (num_r != '0) && (num_r < mrd_r);

  assign div_req.start    = (state_r == ST_CHK) && !below_mr;
  assign div_req.dividend = {num_r, 1'b0} + {{(DIVN_W-TEMP_W){1'b0}}, d_r};
  assign div_req.divisor  = {d_r, 1'b0};

  // issue rule
  logic [PCT_W-1:0] delta;
  logic             issue;

  assign delta = (dem_r > last_cur) ? dem_r - last_cur : last_cur - dem_r;
  assign issue = ((dem_r == '0) && (last_cur != '0)) ||
                 ((dem_r != '0) && (delta >= cfg.deadband));

  assign out_free = !out_tvalid_r || out_tready;

  // sequencer: next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_tvalid) state_nxt = ST_PREP;
      ST_PREP:  state_nxt = ramp ? ST_MUL : ST_APPLY;
      ST_MUL:   state_nxt = ST_CHK;
      ST_CHK:   state_nxt = below_mr ? ST_APPLY : ST_DIV;
      ST_DIV:   if (div_rsp.done) state_nxt = ST_APPLY;
      ST_APPLY: state_nxt = fan_r ? ST_OUT : ST_PREP;
      ST_OUT:   if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // sequencer: outputs
  always_comb begin
    in_tready = 1'b0;
    load_out  = 1'b0;
    unique case (state_r)
      ST_IDLE: in_tready = 1'b1;
      ST_OUT:  load_out  = out_free;
      default: ;
    endcase
  end

  assign accept = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // tick latch
  always_ff @(posedge clk) begin
    if (accept) begin
      supply_r <= in_supply;
      tc_r     <= tc_sel;
      vc_r     <= in_b0_v || in_b1_v;
      ts_r     <= in_sink_t;
      vs_r     <= in_sink_v;
    end
  end

  // fan datapath
  always_ff @(posedge clk) begin
    if (state_r == ST_PREP) begin
      diff_r <= diff_w[TEMP_W-1:0];
      d_r    <= d_w[TEMP_W-1:0];
      dem_r  <= dem_direct;
    end
    if (state_r == ST_MUL) begin
      num_r <= PROD_W'({{(PROD_W-TEMP_W){1'b0}}, diff_r} * PROD_W'(PCT_FULL));
      mrd_r <= PROD_W'(mr_sat) * PROD_W'(d_r);
    end
    if ((state_r == ST_CHK) && below_mr) begin
      dem_r <= mr_sat;
    end
    if ((state_r == ST_DIV) && div_rsp.done) begin
      dem_r <= div_rsp.quotient;
    end
  end

  // command state and fan index
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fan_r       <= 1'b0;
      cap_last_r  <= '0;
      sink_last_r <= '0;
      cap_new_r   <= 1'b0;
      sink_new_r  <= 1'b0;
    end else if (accept) begin
      fan_r <= 1'b0;
    end else if (state_r == ST_APPLY) begin
      fan_r <= !fan_r;
      if (fan_r) begin
        sink_new_r <= issue;
        if (issue) sink_last_r <= dem_r;
      end else begin
        cap_new_r <= issue;
        if (issue) cap_last_r <= dem_r;
      end
    end
  end

  // output register, frees the input side while a result waits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (load_out) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_tdata_r <= {sink_new_r, sink_last_r, cap_new_r, cap_last_r};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

// ===== dv/dual_fan_temp_curve_hysteresis_tb.sv =====
// ----------------------------------------------------------------------------
// dual_fan_temp_curve_hysteresis_tb
// self-checking bench for the two fan curves: drives sensor ticks, keeps its
// own copy of both fan curves and the last commands, and compares every
// command beat field by field under several register settings and traffic
// mixes
// ----------------------------------------------------------------------------
module dual_fan_temp_curve_hysteresis_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import dft_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int DRAIN_CYCLES = 30;     // longer than the worst beat latency
  localparam int PHASE_TICKS = 230;
  localparam int RANDOM_PHASES = 8;

  // command beat as it appears on out_tdata, lowest field last
  typedef struct packed {
    logic             sink_new;
    logic [PCT_W-1:0] sink_pct;
    logic             cap_new;
    logic [PCT_W-1:0] cap_pct;
  } fan_cmds_t;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_tvalid;
  logic              in_tready;
  // supply_ok, sink_temp, sink_valid, board0_temp, board0_valid,
  // board1_temp, board1_valid
  logic [39:0]       in_tdata;
  logic              out_tvalid;
  logic              out_tready;
  // cap_cmd_pct, cap_cmd_new, sink_cmd_pct, sink_cmd_new
  logic [15:0]       out_tdata;
  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [CFG_DW-1:0] cfg_pwdata;
  logic [CFG_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  // shadow of the register file and the two command latches
  cfg_regs_t        fan_cfg;
  logic [PCT_W-1:0] cap_last;
  logic [PCT_W-1:0] sink_last;

  fan_cmds_t awaited_cmds[$];

  int errors = 0;
  int ticks_sent = 0;
  int beats_checked = 0;
  int reg_writes = 0;
  int cycles = 0;

  // traffic shaping, percent of cycles
  int src_idle_pct = 0;
  int sink_stall_pct = 0;

  // sensor random walk
  int sink_t = 0;
  int board0_t = 0;
  int board1_t = 0;

  dual_fan_temp_curve_hysteresis i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #1 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("dual_fan_temp_curve_hysteresis_tb: errors");
      $finish;
    end
  end

  // receiver backpressure
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // ---------------------------------------------------------------------------
  // fan curve prediction
  // ---------------------------------------------------------------------------

  // demand for one fan from its reading; order of checks gives the hysteresis
  function automatic int fan_demand(bit vld, int t, int on, int full, int off,
                                    int last);
    int mr;
    int num;
    int d;
    mr = (fan_cfg.min_run > 7'd100) ? 100 : int'(fan_cfg.min_run);
    if (!vld) return last;
    if (t <= off) return 0;
    if (t < on) return last;          // between off and on points: hold
    if (t >= full) return 100;
    num = (t - on) * 100;
    d = full - on;
    if (num > 0 && num < mr * d) return mr;
    return (2 * num + d) / (2 * d);   // round half up
  endfunction

  // deadband filter; updates the latch when a new command goes out
  function automatic bit issue_cmd(input int demand, inout logic [PCT_W-1:0] last);
    int diff;
    diff = (demand > int'(last)) ? demand - int'(last) : int'(last) - demand;
    if ((demand == 0 && last != '0) ||
        (demand > 0 && diff >= int'(fan_cfg.deadband))) begin
      last = demand[PCT_W-1:0];
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic fan_cmds_t next_fan_cmds(logic [39:0] tick);
    fan_cmds_t r;
    int ts;
    int t0;
    int t1;
    int tc;
    bit v0;
    bit v1;
    int cd;
    int sd;
    if (!tick[0]) begin
      // supply lost: both fans stop, flag only where a fan was running
      r.cap_new = (cap_last != '0);
      r.sink_new = (sink_last != '0);
      cap_last = '0;
      sink_last = '0;
    end else begin
      ts = int'($signed(tick[12:1]));
      t0 = int'($signed(tick[25:14]));
      v0 = tick[26];
      t1 = int'($signed(tick[38:27]));
      v1 = tick[39];
      tc = 0;
      // capacitor fan follows the hotter valid board sensor
      if (v0 && v1) tc = (t0 > t1) ? t0 : t1;
      else if (v0) tc = t0;
      else if (v1) tc = t1;
      cd = fan_demand(v0 || v1, tc, int'($signed(fan_cfg.cap_on)),
                      int'($signed(fan_cfg.cap_full)), int'($signed(fan_cfg.cap_off)),
                      int'(cap_last));
      sd = fan_demand(tick[13], ts, int'($signed(fan_cfg.sink_on)),
                      int'($signed(fan_cfg.sink_full)), int'($signed(fan_cfg.sink_off)),
                      int'(sink_last));
      r.cap_new = issue_cmd(cd, cap_last);
      r.sink_new = issue_cmd(sd, sink_last);
    end
    r.cap_pct = cap_last;
    r.sink_pct = sink_last;
    return r;
  endfunction

  function automatic logic [39:0] pack_tick(bit sup, int ts, bit vs, int t0, bit v0,
                                            int t1, bit v1);
    return {v1, t1[11:0], v0, t0[11:0], vs, ts[11:0], sup};
  endfunction

  function automatic int clamp12(int v);
    if (v < -2048) return -2048;
    if (v > 2047) return 2047;
    return v;
  endfunction

  // ---------------------------------------------------------------------------
  // result checking
  // ---------------------------------------------------------------------------

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    fan_cmds_t got;
    fan_cmds_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      if (awaited_cmds.size() == 0) begin
        $display("%0t: command beat with nothing pending, expected none, got %h",
                 $time, out_tdata);
        errors++;
      end else begin
        want = awaited_cmds.pop_front();
        check_field("cap_cmd_pct", want.cap_pct, got.cap_pct);
        check_field("cap_cmd_new", want.cap_new, got.cap_new);
        check_field("sink_cmd_pct", want.sink_pct, got.sink_pct);
        check_field("sink_cmd_new", want.sink_new, got.sink_new);
        beats_checked++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------------

  // one sensor tick; valid stays up between back-to-back beats
  task automatic send_tick(logic [39:0] tick);
    while ($urandom_range(99) < src_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= tick;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    awaited_cmds.push_back(next_fan_cmds(tick));
    ticks_sent++;
  endtask

  // hold off input until every pending command beat has been seen
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (awaited_cmds.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // register write followed by a read back of the same register
  task automatic set_register(reg_idx_t idx, int value);
    logic [CFG_DW-1:0] mask;
    mask = (idx == REG_MIN_RUN || idx == REG_DEADBAND) ? 32'h7f : 32'hfff;
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    case (idx)
      REG_CAP_ON:    fan_cfg.cap_on = value[11:0];
      REG_CAP_FULL:  fan_cfg.cap_full = value[11:0];
      REG_CAP_OFF:   fan_cfg.cap_off = value[11:0];
      REG_SINK_ON:   fan_cfg.sink_on = value[11:0];
      REG_SINK_FULL: fan_cfg.sink_full = value[11:0];
      REG_SINK_OFF:  fan_cfg.sink_off = value[11:0];
      REG_MIN_RUN:   fan_cfg.min_run = value[6:0];
      REG_DEADBAND:  fan_cfg.deadband = value[6:0];
      default: ;
    endcase
    reg_writes++;
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    if ((cfg_prdata & mask) != (value & mask)) begin
      $display("%0t: register %s read back, expected %h, got %h", $time, idx.name(),
               value & mask, cfg_prdata & mask);
      errors++;
    end
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_curve(int c_on, int c_full, int c_off, int s_on, int s_full,
                             int s_off, int min_run, int deadband);
    wait_idle();
    set_register(REG_CAP_ON, c_on);
    set_register(REG_CAP_FULL, c_full);
    set_register(REG_CAP_OFF, c_off);
    set_register(REG_SINK_ON, s_on);
    set_register(REG_SINK_FULL, s_full);
    set_register(REG_SINK_OFF, s_off);
    set_register(REG_MIN_RUN, min_run);
    set_register(REG_DEADBAND, deadband);
  endtask

  task automatic set_traffic(int src, int sink);
    src_idle_pct = src;
    sink_stall_pct = sink;
  endtask

  // ---------------------------------------------------------------------------
  // random stimulus helpers
  // ---------------------------------------------------------------------------

  // mostly a slow drift around the thresholds so hysteresis and deadband bite
  function automatic int next_temp(int cur, int on, int full, int off);
    int r;
    int lo;
    int hi;
    r = $urandom_range(99);
    lo = clamp12(((on < off) ? on : off) - 40);
    hi = clamp12(((full > on) ? full : on) + 40);
    if (hi < lo) begin
      r = lo;
      lo = hi;
      hi = r;
      r = 50;
    end
    if (r < 75) return clamp12(cur + int'($urandom_range(48)) - 24);
    if (r < 90) return lo + int'($urandom_range(hi - lo));
    return int'($urandom_range(4095)) - 2048;
  endfunction

  task automatic pick_fan_curve(output int on, output int full, output int off);
    if ($urandom_range(9) == 0) begin
      // thresholds in any order
      on = int'($urandom_range(4095)) - 2048;
      full = int'($urandom_range(4095)) - 2048;
      off = int'($urandom_range(4095)) - 2048;
    end else begin
      on = int'($urandom_range(2880)) - 880;
      full = clamp12(on + 1 + int'($urandom_range(399)));
      off = clamp12(on - int'($urandom_range(200)));
    end
  endtask

  task automatic pick_random_curve();
    int c_on;
    int c_full;
    int c_off;
    int s_on;
    int s_full;
    int s_off;
    int mr;
    int db;
    pick_fan_curve(c_on, c_full, c_off);
    pick_fan_curve(s_on, s_full, s_off);
    mr = ($urandom_range(4) == 0) ? 101 + int'($urandom_range(26)) : int'($urandom_range(100));
    case ($urandom_range(9))
      0:       db = 101 + int'($urandom_range(26));
      1, 2:    db = int'($urandom_range(100));
      default: db = int'($urandom_range(10));
    endcase
    apply_curve(c_on, c_full, c_off, s_on, s_full, s_off, mr, db);
  endtask

  task automatic send_random_tick();
    sink_t = next_temp(sink_t, int'($signed(fan_cfg.sink_on)),
                       int'($signed(fan_cfg.sink_full)), int'($signed(fan_cfg.sink_off)));
    board0_t = next_temp(board0_t, int'($signed(fan_cfg.cap_on)),
                         int'($signed(fan_cfg.cap_full)), int'($signed(fan_cfg.cap_off)));
    board1_t = next_temp(board1_t, int'($signed(fan_cfg.cap_on)),
                         int'($signed(fan_cfg.cap_full)), int'($signed(fan_cfg.cap_off)));
    send_tick(pack_tick($urandom_range(99) < 95, sink_t, $urandom_range(99) < 88,
                        board0_t, $urandom_range(99) < 88,
                        board1_t, $urandom_range(99) < 88));
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // curve under the reset thresholds
  task automatic test_default_curve();
    set_traffic(0, 0);
    send_tick(pack_tick(1, 0, 0, 0, 0, 0, 0));               // nothing valid, hold at 0
    send_tick(pack_tick(1, 2047, 1, 2047, 1, -2048, 1));     // both full
    send_tick(pack_tick(1, 2047, 1, 2047, 1, -2048, 1));     // repeat, inside deadband
    send_tick(pack_tick(1, 900, 1, 700, 1, 800, 1));         // ramps, hotter board wins
    send_tick(pack_tick(1, 901, 1, 801, 0, 810, 0));         // no board sensor: hold
    send_tick(pack_tick(1, 600, 1, 600, 1, 600, 0));         // cap holds, sink at off
    send_tick(pack_tick(1, 721, 1, 641, 1, 641, 1));         // lifted to min run
    send_tick(pack_tick(0, 2047, 1, 2047, 1, 2047, 1));      // supply drop
    send_tick(pack_tick(0, 2047, 1, 2047, 1, 2047, 1));      // still down, nothing new
    send_tick(pack_tick(1, 720, 1, -2048, 0, 640, 1));       // exactly at on point
    send_tick(pack_tick(1, 2047, 1, 2047, 1, 2047, 1));
    send_tick(pack_tick(1, 1000, 1, 840, 0, 840, 1));        // half-way rounds up
    send_tick(pack_tick(1, -2048, 1, -2048, 1, -2048, 1));   // coldest
    send_tick(pack_tick(1, 1119, 1, 959, 1, 2, 1));          // just under full
  endtask

  // saturating min run, zero and huge deadband, reversed thresholds
  task automatic test_config_extremes();
    apply_curve(-2048, 2047, -2048, 100, 50, 300, 127, 0);
    send_tick(pack_tick(1, 200, 1, -2047, 1, 0, 0));         // min run clipped to 100
    send_tick(pack_tick(1, 400, 1, 0, 1, -2047, 1));         // reissued with no deadband
    send_tick(pack_tick(1, 400, 1, 0, 1, -2047, 1));
    send_tick(pack_tick(1, 250, 1, -2048, 1, 0, 0));         // at cap off point
    apply_curve(0, 1000, -1, 2047, 2047, -2048, 0, 100);
    send_tick(pack_tick(1, 2047, 1, 5, 1, 0, 0));            // no min run, tiny ramp
    send_tick(pack_tick(1, 2046, 1, 999, 1, 0, 0));          // step of exactly the deadband
    send_tick(pack_tick(1, -2048, 1, 0, 1, 0, 1));           // drop to zero always issues
    apply_curve(640, 960, 560, 720, 1120, 640, 100, 127);
    send_tick(pack_tick(1, 1120, 1, 960, 1, 0, 0));          // deadband wider than range
    send_tick(pack_tick(0, 1120, 1, 960, 1, 0, 0));
  endtask

  // random ticks over several curves and traffic mixes
  task automatic test_random_sweep();
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      pick_random_curve();
      case (p % 4)
        0: set_traffic(0, 0);
        1: set_traffic(79, 0);
        2: set_traffic(0, 79);
        default: set_traffic(18, 18);
      endcase
      for (int i = 0; i < PHASE_TICKS; i++) begin
        // sender holds off mid-phase until the block has drained
        if (p == 1 && i == PHASE_TICKS / 2) wait_idle();
        send_random_tick();
      end
    end
  endtask

  initial begin
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    out_tready <= 1'b0;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    cfg_paddr <= '0;
    cfg_pwdata <= '0;
    fan_cfg.cap_on = 12'sd640;
    fan_cfg.cap_full = 12'sd960;
    fan_cfg.cap_off = 12'sd560;
    fan_cfg.sink_on = 12'sd720;
    fan_cfg.sink_full = 12'sd1120;
    fan_cfg.sink_off = 12'sd640;
    fan_cfg.min_run = 7'd20;
    fan_cfg.deadband = 7'd3;
    cap_last = '0;
    sink_last = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_default_curve();
    test_config_extremes();
    test_random_sweep();
    wait_idle();

    $display("%0d sensor ticks, %0d command beats compared, %0d register writes",
             ticks_sent, beats_checked, reg_writes);
    $display("default and extreme curves, supply loss, hold band, deadband, four traffic mixes");
    if (errors == 0) begin
      $display("dual_fan_temp_curve_hysteresis_tb: clean");
    end else begin
      $display("dual_fan_temp_curve_hysteresis_tb: errors");
    end
    $finish;
  end

endmodule

// ===== dual_fan_temp_curve_hysteresis.f =====
rtl/dft_pkg.sv
rtl/dft_cfg.sv
rtl/dft_div.sv
rtl/dual_fan_temp_curve_hysteresis.sv
dv/dual_fan_temp_curve_hysteresis_tb.sv
